[rtl/assert_macros.svh]
// Assertion helpers for the checksum block checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ics_pkg.sv]
package ics_pkg;

    localparam int unsigned LANES  = 8;
    localparam int unsigned CNT_W  = 4;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned SUM_W  = 32;
    localparam int unsigned PART_W = OFF_W + $clog2(LANES);

    localparam logic [OFF_W-1:0] MAX_BYTES = 16'hFFFF;

    typedef struct packed {
        logic [OFF_W-1:0] contrib;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        logic [PART_W-1:0] partial;
        logic              first;
        logic [SUM_W-1:0]  init;
        logic              last;
        logic [OFF_W-1:0]  total;
        logic              ovf;
    } word_t;

endpackage

[rtl/ics_lane.sv]
module ics_lane (
    input  logic [7:0]             lane_byte,
    input  logic                   active,
    input  logic [ics_pkg::OFF_W:0] off,
    input  logic                   field_en,
    input  logic [ics_pkg::OFF_W-1:0] field_pos,
    output ics_pkg::lane_t         result
);
    import ics_pkg::*;

    logic [OFF_W:0] pos_ext;
    logic           in_range;
    logic           in_field;

    assign pos_ext  = {1'b0, field_pos};
    assign in_range = off < {1'b0, MAX_BYTES};
    assign in_field = field_en && ((off == pos_ext) || (off == pos_ext + 1'b1));

    always_comb
    begin
        result.ovf     = active && !in_range;
        result.contrib = '0;
        if (active && in_range && !in_field)
        begin
            result.contrib = off[0] ? {8'h00, lane_byte} : {lane_byte, 8'h00};
        end
    end

endmodule

[rtl/ics_accum.sv]
module ics_accum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ics_pkg::word_t            word,
    input  logic                      word_valid,
    output logic                      word_take,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               checksum,
    output logic [ics_pkg::OFF_W-1:0] byte_total,
    output logic                      too_long
);
    import ics_pkg::*;

    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      checksum_reg;
    logic [OFF_W-1:0] total_reg;
    logic             too_long_reg;

    assign word_take = word_valid && (!word.last || !out_valid_reg || out_ready);

    always_comb
    begin
        acc_next = (word.first ? word.init : acc_reg) + SUM_W'(word.partial);
        fold1    = {1'b0, acc_next[15:0]} + {1'b0, acc_next[31:16]};
        fold2    = fold1[15:0] + {15'b0, fold1[16]};
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (word_take && word.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            acc_reg <= acc_next;
            if (word.last)
            begin
                checksum_reg <= ~fold2;
                total_reg    <= word.total;
                too_long_reg <= word.ovf;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign checksum   = checksum_reg;
    assign byte_total = total_reg;
    assign too_long   = too_long_reg;

endmodule

[rtl/internet_checksum_stream.sv]
// Channel | Direction | Handshake          | Payload
// in      | sink      | in_valid/in_ready  | data, valid_bytes, last, initial_req,
//         |           |                    | zero_enable, zero_pos
// out     | source    | out_valid/out_ready| checksum, byte_total, too_long
//
// One word per cycle unless stalled; eight byte lanes and an adder tree sum it.
// A packet result is registered after its last word leaves the word register.
// The running offset and the 32-bit accumulator each update once per word taken.
// Reset clears the packet offset and both valid flags.
// A held result stalls a following last word and all input behind it.
module internet_checksum_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data,
    input  logic [3:0]  valid_bytes,
    input  logic        last,
    input  logic [31:0] initial_req,
    input  logic        zero_enable,
    input  logic [15:0] zero_pos,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] checksum,
    output logic [15:0] byte_total,
    output logic        too_long
);
    import ics_pkg::*;

    logic [OFF_W-1:0]  offset_reg;
    logic [OFF_W-1:0]  offset_next;
    logic [OFF_W-1:0]  pos_reg;
    logic              en_reg;
    logic              ovf_reg;
    word_t             word_reg;
    word_t             word_next;
    logic              word_valid_reg;
    logic              word_valid_next;
    logic              word_take;
    logic              accept;
    logic              first;
    logic [OFF_W-1:0]  pos_eff;
    logic              en_eff;
    logic [CNT_W-1:0]  cnt;
    logic [OFF_W:0]    end_off;
    logic [OFF_W-1:0]  new_off;
    logic [PART_W-1:0] partial;
    logic              ovf_any;
    lane_t             lane_res [LANES];

    assign accept   = in_valid && in_ready;
    assign in_ready = !word_valid_reg || word_take;
    assign first    = offset_reg == '0;
    assign pos_eff  = first ? zero_pos : pos_reg;
    assign en_eff   = first ? zero_enable : en_reg;
    assign cnt      = (valid_bytes > CNT_W'(LANES)) ? CNT_W'(LANES) : valid_bytes;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        ics_lane u_lane (
            .lane_byte (data[8*i +: 8]),
            .active    (CNT_W'(i) < cnt),
            .off       ({1'b0, offset_reg} + (OFF_W+1)'(i)),
            .field_en  (en_eff),
            .field_pos (pos_eff),
            .result    (lane_res[i])
        );
    end

    always_comb
    begin
        partial = '0;
        ovf_any = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            partial = partial + PART_W'(lane_res[i].contrib);
            ovf_any = ovf_any | lane_res[i].ovf;
        end
    end

    always_comb
    begin
        end_off = {1'b0, offset_reg} + (OFF_W+1)'(cnt);
        new_off = (end_off >= {1'b0, MAX_BYTES}) ? MAX_BYTES : end_off[OFF_W-1:0];
        offset_next = last ? '0 : new_off;

        word_next.partial = partial;
        word_next.first   = first;
        word_next.init    = initial_req;
        word_next.last    = last;
        word_next.total   = new_off;
        word_next.ovf     = (ovf_reg && !first) || ovf_any;

        word_valid_next = word_valid_reg;
        if (accept)
        begin
            word_valid_next = 1'b1;
        end
        else if (word_take)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            pos_reg        <= '0;
            en_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
            if (accept)
            begin
                offset_reg <= offset_next;
                pos_reg    <= pos_eff;
                en_reg     <= en_eff;
                ovf_reg    <= word_next.ovf && !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    ics_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word_reg),
        .word_valid (word_valid_reg),
        .word_take  (word_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .checksum   (checksum),
        .byte_total (byte_total),
        .too_long   (too_long)
    );

endmodule

[rtl/ics_checker.sv]
`include "assert_macros.svh"

module ics_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [63:0] data,
    input logic [3:0]  valid_bytes,
    input logic        last,
    input logic [31:0] initial_req,
    input logic        zero_enable,
    input logic [15:0] zero_pos,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] checksum,
    input logic [15:0] byte_total,
    input logic        too_long
);

    // hold a stalled result
    `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `AST_NEXT(a_out_stable, out_valid && !out_ready, $stable(checksum) && $stable(byte_total) && $stable(too_long))
    // an overlong packet saturates its length
    `AST_SAME(a_long_sat, out_valid && too_long, byte_total == 16'hFFFF)
    // a second packet end cannot pass a held result
    `AST_SAME(a_last_block, (in_valid && in_ready && last && out_valid && !out_ready) ##1 (out_valid && !out_ready), !in_ready)

endmodule

bind internet_checksum_stream ics_checker u_ics_checker (.*);

[tb/internet_checksum_checker.sv]
`timescale 1ns / 1ps

module internet_checksum_checker
    import ics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] data,
    input  logic [3:0]  valid_bytes,
    input  logic        last,
    input  logic [31:0] initial_req,
    input  logic        zero_enable,
    input  logic [15:0] zero_pos,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] checksum,
    input  logic [15:0] byte_total,
    input  logic        too_long,
    output int          mismatch_count,
    output int          pending_results
);

    typedef struct {
        logic [15:0] checksum;
        logic [15:0] byte_total;
        logic        too_long;
    } csum_result_t;

    csum_result_t csum_q[$];

    logic [31:0] acc_sum;
    int unsigned pkt_offset;
    int unsigned field_at;
    logic        field_on;
    logic        overflow;

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    task automatic clear_packet();
        acc_sum    = '0;
        pkt_offset = 0;
        field_at   = 0;
        field_on   = 1'b0;
        overflow   = 1'b0;
    endtask

    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        logic [31:0] f;
        f = s;
        while (f[31:16] != 16'h0)
            f = {16'h0, f[15:0]} + {16'h0, f[31:16]};
        return f[15:0];
    endfunction

    task automatic absorb_word(input logic [63:0] d, input logic [3:0] vb, input logic lst,
                               input logic [31:0] init, input logic ze, input logic [15:0] zp);
        int unsigned  n;
        int unsigned  lane;
        logic [31:0]  b;
        csum_result_t r;
        n = (32'(vb) > LANES) ? LANES : 32'(vb);
        if (pkt_offset == 0) begin
            acc_sum  = init;
            field_on = ze;
            field_at = 32'(zp);
            overflow = 1'b0;
        end
        for (lane = 0; lane < n; lane++) begin
            if (pkt_offset >= 32'(MAX_BYTES)) begin
                overflow = 1'b1;
            end
            else begin
                b = {24'h0, d[8*lane +: 8]};
                if (field_on && (pkt_offset == field_at || pkt_offset == field_at + 1))
                    b = '0;
                acc_sum    = acc_sum + (pkt_offset[0] ? b : (b << 8));
                pkt_offset = pkt_offset + 1;
            end
        end
        if (lst) begin
            r.checksum   = ~fold_sum(acc_sum);
            r.byte_total = pkt_offset[15:0];
            r.too_long   = overflow;
            csum_q.push_back(r);
            clear_packet();
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch expected %h actual %h", $time, fname, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        csum_result_t r;
        if (!rst_n) begin
            clear_packet();
            csum_q.delete();
        end
        else begin
            if (in_valid && in_ready)
                absorb_word(data, valid_bytes, last, initial_req, zero_enable, zero_pos);
            if (out_valid && out_ready) begin
                if (csum_q.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h/%h/%b",
                             $time, checksum, byte_total, too_long);
                    mismatch_count++;
                end
                else begin
                    r = csum_q.pop_front();
                    check_field("checksum", r.checksum, checksum);
                    check_field("byte_total", r.byte_total, byte_total);
                    check_field("too_long", {15'h0, r.too_long}, {15'h0, too_long});
                end
            end
        end
        pending_results = csum_q.size();
    end

endmodule

[tb/tb_internet_checksum_stream.sv]
`timescale 1ns / 1ps

module tb_internet_checksum_stream;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data;
    logic [3:0]  valid_bytes;
    logic        last;
    logic [31:0] initial_req;
    logic        zero_enable;
    logic [15:0] zero_pos;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] checksum;
    logic [15:0] byte_total;
    logic        too_long;
    int          mismatch_count;
    int          pending_results;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          words_sent;

    internet_checksum_stream u_top (.*);

    internet_checksum_checker u_checker (.*);

    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("tb_internet_checksum_stream: FAIL");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ready <= (rst_n && $urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input logic [63:0] d, input logic [3:0] vb, input logic lst,
                             input logic [31:0] init, input logic ze, input logic [15:0] zp);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data        <= d;
        valid_bytes <= vb;
        last        <= lst;
        initial_req <= init;
        zero_enable <= ze;
        zero_pos    <= zp;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand_data();
        return ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
    endfunction

    task automatic send_random_packet();
        int          nwords;
        int          k;
        logic [3:0]  vb;
        logic [31:0] init;
        logic        ze;
        logic [15:0] zp;
        nwords = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        case ($urandom_range(3))
            0:       init = '0;
            1:       init = '1;
            default: init = $urandom;
        endcase
        ze = 1'($urandom_range(1));
        zp = ($urandom_range(4) == 0) ? 16'($urandom_range(65534))
                                      : 16'($urandom_range(nwords * 8));
        for (k = 0; k < nwords; k++) begin
            vb = (k == nwords - 1) ? 4'($urandom_range(8, 1)) : 4'd8;
            if ($urandom_range(19) == 0)
                vb = 4'($urandom_range(15));
            send_word(rand_data(), vb, k == nwords - 1, init, ze, zp);
            // later words must not reload the packet settings
            init = $urandom;
            ze   = 1'($urandom_range(1));
            zp   = 16'($urandom_range(65534));
        end
    endtask

    task automatic run_random(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
            send_random_packet();
    endtask

    initial begin
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data        = '0;
        valid_bytes = '0;
        last        = 1'b0;
        initial_req = '0;
        zero_enable = 1'b0;
        zero_pos    = '0;
        hold_req    = 1'b0;
        words_sent  = 0;
        tx_idle_pct = 15;
        rx_idle_pct = 57;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty packet
        send_word('1, 4'd0, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'h0);
        // empty leading word restarts the packet
        send_word('1, 4'd0, 1'b0, 32'h1234_5678, 1'b1, 16'h0);
        send_word(64'h0123_4567_89AB_CDEF, 4'd8, 1'b1, 32'h0000_0001, 1'b0, 16'h0);
        send_word('1, 4'd8, 1'b1, 32'h0, 1'b0, 16'h0);
        send_word('0, 4'd8, 1'b1, 32'hFFFF_FFFF, 1'b0, 16'hFFFE);
        // count above word size clamps
        send_word(64'hFEDC_BA98_7654_3210, 4'd15, 1'b1, 32'h0, 1'b0, 16'h0);
        send_word(64'hA5A5_5A5A_FFFF_0000, 4'd9, 1'b1, 32'h8000_0000, 1'b0, 16'h0);
        // trailing odd byte
        send_word(64'h0000_0000_00AB_CDEF, 4'd3, 1'b1, 32'h0, 1'b0, 16'h0);
        // checksum field inside, at the last offset, out of reach, across a word
        send_word('1, 4'd8, 1'b0, 32'h0, 1'b1, 16'd2);
        send_word('1, 4'd8, 1'b1, 32'h0, 1'b0, 16'd0);
        send_word('1, 4'd5, 1'b1, 32'h0, 1'b1, 16'd4);
        send_word('1, 4'd8, 1'b1, 32'h0, 1'b1, 16'd65534);
        send_word(64'h1122_3344_5566_7788, 4'd8, 1'b0, 32'hFFFF_0000, 1'b1, 16'd7);
        send_word(64'h99AA_BBCC_DDEE_FF00, 4'd8, 1'b1, 32'h0, 1'b0, 16'd0);
        // odd-length middle words
        send_word(64'hFFFF_FFFF_FF01_0203, 4'd3, 1'b0, 32'h0000_FFFF, 1'b1, 16'd3);
        send_word(64'hFFFF_FF04_0506_0708, 4'd5, 1'b0, 32'h0, 1'b0, 16'd0);
        send_word(64'h0, 4'd0, 1'b0, 32'h0, 1'b0, 16'd0);
        send_word(64'hFFFF_FFFF_FFFF_FF09, 4'd1, 1'b1, 32'h0, 1'b0, 16'd0);

        run_random(400);

        tx_idle_pct = 57;
        rx_idle_pct = 15;
        run_random(400);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // stall the output and keep offering results until the input backs up
        hold_req = 1'b1;
        for (k = 0; k < 12; k++)
            send_word(rand_data(), 4'($urandom_range(8, 1)), 1'b1, $urandom,
                      1'($urandom_range(1)), 16'($urandom_range(8)));
        run_random(400);

        in_valid <= 1'b0;
        wait (pending_results == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_internet_checksum_stream: PASS");
        else
            $display("tb_internet_checksum_stream: FAIL");
        $finish;
    end

endmodule
